>>> rtl/ibm_pkg.sv
// Shared constants and types for the inode block map allocator.
package ibm_pkg;

	// Geometry
	localparam int DIRECT_ENTRIES   = 13;
	localparam int INDIRECT_ENTRIES = 512;
	localparam int INODE_COUNT      = 8;
	localparam int DISK_BLOCKS      = 4096;
	localparam int FIRST_FREE       = 6;

	// Field widths
	localparam int INO_W = 3;
	localparam int LB_W  = 10;
	localparam int PB_W  = 12;
	localparam int ST_W  = 2;
	localparam int NB_W  = 2;

	// Store sizes
	localparam int DIR_DEPTH = INODE_COUNT * DIRECT_ENTRIES;
	localparam int DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
	localparam int IND_DEPTH = INODE_COUNT * INDIRECT_ENTRIES;
	localparam int IND_AW    = $clog2(IND_DEPTH);
	localparam int INO_AW    = (INODE_COUNT > 1) ? $clog2(INODE_COUNT) : 1;
	// bump counter holds up to DISK_BLOCKS, sums reach DISK_BLOCKS + 2
	localparam int CNT_W     = $clog2(DISK_BLOCKS + 3);

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Result of one item
	typedef struct packed {
		logic [PB_W-1:0] physical_block;
		logic [ST_W-1:0] status;
		logic [NB_W-1:0] new_blocks;
	} ibm_rsp_t;

	// Write-back commands from the evaluation logic
	typedef struct packed {
		logic              dir_we;
		logic [PB_W-1:0]   dir_data;
		logic              ibn_we;
		logic [PB_W-1:0]   ibn_data;
		logic              ind_we;
		logic [PB_W-1:0]   ind_data;
		logic [CNT_W-1:0]  cnt_next;
	} ibm_upd_t;

endpackage

>>> rtl/ibm_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module ibm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ibm_eval.sv
// Map lookup, range and disk-full checks, and allocation decisions.
module ibm_eval (
	input  logic [ibm_pkg::INO_W-1:0]  ino,
	input  logic [ibm_pkg::LB_W-1:0]   lb,
	input  logic                       dir_valid,
	input  logic [ibm_pkg::PB_W-1:0]   dir_rdata,
	input  logic [ibm_pkg::PB_W-1:0]   ibn,
	input  logic [ibm_pkg::PB_W-1:0]   ind_rdata,
	input  logic [ibm_pkg::CNT_W-1:0]  cnt,
	output ibm_pkg::ibm_rsp_t          rsp,
	output ibm_pkg::ibm_upd_t          upd
);
	import ibm_pkg::*;

	logic             range_err;
	logic             is_dir;
	logic [PB_W-1:0]  cur;
	logic             need_ibn;
	logic             need_ent;
	logic [CNT_W-1:0] need;
	logic             full;
	logic [CNT_W-1:0] ent_blk;

	always_comb begin
		range_err = (int'(ino) >= INODE_COUNT) ||
		            (int'(lb) >= DIRECT_ENTRIES + INDIRECT_ENTRIES);
		is_dir    = int'(lb) < DIRECT_ENTRIES;

		// an inode with no indirect block has only empty indirect slots
		if (is_dir) begin
			cur = dir_valid ? dir_rdata : '0;
		end else begin
			cur = (ibn != '0) ? ind_rdata : '0;
		end

		need_ibn = !is_dir && (ibn == '0);
		need_ent = (cur == '0);
		need     = CNT_W'(need_ibn) + CNT_W'(need_ent);
		full     = (need != '0) && (int'(cnt) + int'(need) > DISK_BLOCKS);
		ent_blk  = cnt + CNT_W'(need_ibn);

		rsp = '0;
		upd = '0;
		upd.cnt_next = cnt;
		if (range_err) begin
			rsp.status = ST_RANGE;
		end else if (full) begin
			rsp.status = ST_FULL;
		end else begin
			rsp.status     = ST_OK;
			rsp.new_blocks = NB_W'(need);
			rsp.physical_block = need_ent ? PB_W'(ent_blk) : cur;
			upd.cnt_next   = cnt + need;
			upd.ibn_we     = need_ibn;
			upd.ibn_data   = PB_W'(cnt);
			upd.dir_we     = is_dir && need_ent;
			upd.dir_data   = PB_W'(ent_blk);
			upd.ind_we     = !is_dir && need_ent;
			upd.ind_data   = PB_W'(ent_blk);
		end
	end

endmodule

>>> rtl/inode_block_map_allocator_top.sv
// Top level of the inode block map allocator: sequencer, stores and result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------
//  request | req_valid | req_stall | inode_index, logical_block
//  result  | rsp_valid | rsp_stall | physical_block, status, new_blocks
//
// The map RAMs are read at the accepting edge, and the edge that leaves the
// evaluation state writes back any new mapping and loads the result register.
// A stalled result holds the item in the evaluation state until the register frees.
// Reset clears the direct-map valid bits and the per-inode indirect block
// numbers at once, then a clearing pass zeroes all 4096 slots of the indirect
// map RAM one slot a cycle, with the request side stalled throughout. The
// allocation bitmap is the run of blocks below the bump counter, which reset
// sets to 6.
module inode_block_map_allocator_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [ibm_pkg::INO_W-1:0]  inode_index,
	input  logic [ibm_pkg::LB_W-1:0]   logical_block,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [ibm_pkg::PB_W-1:0]   physical_block,
	output logic [ibm_pkg::ST_W-1:0]   status,
	output logic [ibm_pkg::NB_W-1:0]   new_blocks
);
	import ibm_pkg::*;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EVAL  = 2'd2;

	logic [1:0]         state_q;
	logic               accept;
	logic               done;
	logic               clearing;
	logic [IND_AW-1:0]  clr_q;
	logic [INO_W-1:0]   ino_s1;
	logic [LB_W-1:0]    lb_s1;
	logic [DIR_AW-1:0]  dir_slot_s1;
	logic [IND_AW-1:0]  ind_slot_s1;
	logic [DIR_AW-1:0]  dir_raddr;
	logic [IND_AW-1:0]  ind_raddr;
	logic               ind_we;
	logic [IND_AW-1:0]  ind_waddr;
	logic [PB_W-1:0]    ind_wdata;
	logic [PB_W-1:0]    dir_rdata;
	logic [PB_W-1:0]    ind_rdata;
	logic [DIR_DEPTH-1:0] dvalid_q;
	logic [PB_W-1:0]    ibn_q [INODE_COUNT];
	logic [CNT_W-1:0]   cnt_q;
	logic               dir_valid;
	logic [PB_W-1:0]    ibn;
	ibm_rsp_t           rsp;
	ibm_upd_t           upd;
	logic               rsp_valid_q;
	ibm_rsp_t           rsp_q;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign done      = (state_q == S_EVAL) && (!rsp_valid_q || !rsp_stall);
	assign clearing  = (state_q == S_CLEAR);

	// slot addresses from the request ports
	assign dir_raddr = DIR_AW'(int'(inode_index) * DIRECT_ENTRIES + int'(logical_block));
	assign ind_raddr = IND_AW'(int'(inode_index) * INDIRECT_ENTRIES +
	                           int'(logical_block) - DIRECT_ENTRIES);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (clr_q == IND_AW'(IND_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (done) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// clearing pass over the indirect map after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			ino_s1      <= inode_index;
			lb_s1       <= logical_block;
			dir_slot_s1 <= dir_raddr;
			ind_slot_s1 <= ind_raddr;
		end
	end

	ibm_ram #(.DEPTH(DIR_DEPTH), .WIDTH(PB_W), .AW(DIR_AW)) u_dir_ram (
		.clk   (clk),
		.we    (done && upd.dir_we),
		.waddr (dir_slot_s1),
		.wdata (upd.dir_data),
		.re    (accept),
		.raddr (dir_raddr),
		.rdata (dir_rdata)
	);

	// indirect write port: zeroes during the clearing pass, else write-back
	assign ind_we    = clearing || (done && upd.ind_we);
	assign ind_waddr = clearing ? clr_q : ind_slot_s1;
	assign ind_wdata = clearing ? '0 : upd.ind_data;

	ibm_ram #(.DEPTH(IND_DEPTH), .WIDTH(PB_W), .AW(IND_AW)) u_ind_ram (
		.clk   (clk),
		.we    (ind_we),
		.waddr (ind_waddr),
		.wdata (ind_wdata),
		.re    (accept),
		.raddr (ind_raddr),
		.rdata (ind_rdata)
	);

	// lookups of the flop stores, guarded against codes past the inode range
	always_comb begin
		dir_valid = 1'b0;
		ibn       = '0;
		if (int'(ino_s1) < INODE_COUNT) begin
			ibn = ibn_q[INO_AW'(ino_s1)];
			if (int'(lb_s1) < DIRECT_ENTRIES) begin
				dir_valid = dvalid_q[dir_slot_s1];
			end
		end
	end

	ibm_eval u_eval (
		.ino       (ino_s1),
		.lb        (lb_s1),
		.dir_valid (dir_valid),
		.dir_rdata (dir_rdata),
		.ibn       (ibn),
		.ind_rdata (ind_rdata),
		.cnt       (cnt_q),
		.rsp       (rsp),
		.upd       (upd)
	);

	// bump counter, direct valid bits, indirect block numbers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= CNT_W'(FIRST_FREE);
			dvalid_q <= '0;
			for (int i = 0; i < INODE_COUNT; i++) ibn_q[i] <= '0;
		end else if (done) begin
			cnt_q <= upd.cnt_next;
			if (upd.dir_we) dvalid_q[dir_slot_s1] <= 1'b1;
			if (upd.ibn_we) ibn_q[INO_AW'(ino_s1)] <= upd.ibn_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) rsp_q <= rsp;
	end

	assign rsp_valid      = rsp_valid_q;
	assign physical_block = rsp_q.physical_block;
	assign status         = rsp_q.status;
	assign new_blocks     = rsp_q.new_blocks;

endmodule

>>> tb/tb_inode_block_map_allocator_top.sv
// Self-checking testbench for the inode block map allocator: directed table and random traffic.
module tb_inode_block_map_allocator_top;
	import ibm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1728;
	localparam int DRAIN_CYCLES = 10;
	localparam int IDLE_PCT     = 7;
	localparam int LB_LAST      = DIRECT_ENTRIES + INDIRECT_ENTRIES - 1;
	localparam int PLAN_ROWS    = 22;

	// One row of the directed table; rsp is used only where typed is set
	typedef struct packed {
		logic [INO_W-1:0] ino;
		logic [LB_W-1:0]  lb;
		logic             typed;
		ibm_rsp_t         rsp;
	} plan_row_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             req_valid     = 1'b0;
	logic             req_stall;
	logic [INO_W-1:0] inode_index   = '0;
	logic [LB_W-1:0]  logical_block = '0;
	logic             rsp_valid;
	logic             rsp_stall     = 1'b0;
	logic [PB_W-1:0]  physical_block;
	logic [ST_W-1:0]  status;
	logic [NB_W-1:0]  new_blocks;

	// Predictor copy of the block's maps and bump counter
	logic [PB_W-1:0] dir_map [DIR_DEPTH];
	logic [PB_W-1:0] ind_blk [INODE_COUNT];
	logic [PB_W-1:0] ind_map [IND_DEPTH];
	bit              used_map [DISK_BLOCKS];
	int unsigned     free_ptr;

	ibm_rsp_t pending_rsp [$];

	bit calm = 1'b0;
	int fails      = 0;
	int n_sent     = 0;
	int n_checked  = 0;
	int n_taken    = 0;
	int n_full     = 0;
	int n_range    = 0;
	int cycle_count = 0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{3'd0, 10'd0,    1'b1, '{12'd6,  ST_OK,    2'd1}},
		'{3'd0, 10'd0,    1'b1, '{12'd6,  ST_OK,    2'd0}},
		'{3'd0, 10'd13,   1'b1, '{12'd8,  ST_OK,    2'd2}},
		'{3'd0, 10'd14,   1'b1, '{12'd9,  ST_OK,    2'd1}},
		'{3'd0, 10'd13,   1'b1, '{12'd8,  ST_OK,    2'd0}},
		'{3'd0, 10'd524,  1'b1, '{12'd10, ST_OK,    2'd1}},
		'{3'd0, 10'd525,  1'b1, '{12'd0,  ST_RANGE, 2'd0}},
		'{3'd7, 10'd1023, 1'b1, '{12'd0,  ST_RANGE, 2'd0}},
		'{3'd7, 10'd12,   1'b1, '{12'd11, ST_OK,    2'd1}},
		'{3'd7, 10'd524,  1'b0, '0},
		'{3'd3, 10'd12,   1'b0, '0},
		'{3'd5, 10'd600,  1'b1, '{12'd0,  ST_RANGE, 2'd0}},
		'{3'd0, 10'd12,   1'b0, '0},
		'{3'd1, 10'd1,    1'b0, '0},
		'{3'd2, 10'd2,    1'b0, '0},
		'{3'd4, 10'd4,    1'b0, '0},
		'{3'd6, 10'd100,  1'b0, '0},
		'{3'd6, 10'd100,  1'b0, '0},
		'{3'd3, 10'd13,   1'b0, '0},
		'{3'd7, 10'd0,    1'b0, '0},
		'{3'd5, 10'd512,  1'b0, '0},
		'{3'd1, 10'd526,  1'b1, '{12'd0,  ST_RANGE, 2'd0}}
	};

	inode_block_map_allocator_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.inode_index    (inode_index),
		.logical_block  (logical_block),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.physical_block (physical_block),
		.status         (status),
		.new_blocks     (new_blocks)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hand out the next block from the bump counter
	function automatic logic [PB_W-1:0] take_next();
		logic [PB_W-1:0] b;
		b = free_ptr[PB_W-1:0];
		if (free_ptr < DISK_BLOCKS)
			used_map[free_ptr] = 1'b1;
		free_ptr = free_ptr + 1;
		n_taken++;
		return b;
	endfunction

	// Map one logical block, allocating on demand
	function automatic ibm_rsp_t resolve_block(input logic [INO_W-1:0] ino,
			input logic [LB_W-1:0] lb);
		ibm_rsp_t    r;
		int unsigned dslot;
		int unsigned islot;
		int unsigned off;
		int unsigned need;
		r = '{physical_block: '0, status: ST_RANGE, new_blocks: '0};
		if (ino >= INODE_COUNT)
			return r;
		if (lb < DIRECT_ENTRIES) begin
			dslot = ino * DIRECT_ENTRIES + lb;
			if (dir_map[dslot] == '0) begin
				if (free_ptr + 1 > DISK_BLOCKS) begin
					r.status = ST_FULL;
					return r;
				end
				dir_map[dslot] = take_next();
				r.new_blocks = 2'd1;
			end
			r.physical_block = dir_map[dslot];
			r.status = ST_OK;
			return r;
		end
		off = lb - DIRECT_ENTRIES;
		if (off >= INDIRECT_ENTRIES)
			return r;
		islot = ino * INDIRECT_ENTRIES + off;
		need = 0;
		if (ind_blk[ino] == '0)
			need++;
		if (ind_map[islot] == '0)
			need++;
		// nothing is taken unless every block the item needs is free
		if (need != 0 && free_ptr + need > DISK_BLOCKS) begin
			r.status = ST_FULL;
			return r;
		end
		if (ind_blk[ino] == '0) begin
			ind_blk[ino] = take_next();
			r.new_blocks = r.new_blocks + 2'd1;
		end
		if (ind_map[islot] == '0) begin
			ind_map[islot] = take_next();
			r.new_blocks = r.new_blocks + 2'd1;
		end
		r.physical_block = ind_map[islot];
		r.status = ST_OK;
		return r;
	endfunction

	// Drive one request item, hold it until accepted, then record what must come back
	task automatic issue_request(input logic [INO_W-1:0] ino, input logic [LB_W-1:0] lb,
			input logic typed, input ibm_rsp_t typed_rsp);
		ibm_rsp_t want;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid     <= 1'b1;
		inode_index   <= ino;
		logical_block <= lb;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		want = resolve_block(ino, lb);
		if (typed)
			want = typed_rsp;
		if (want.status == ST_FULL)
			n_full++;
		if (want.status == ST_RANGE)
			n_range++;
		pending_rsp.push_back(want);
		n_sent++;
	endtask

	// Random item over the whole field space, biased towards mapped entries
	task automatic random_request();
		logic [INO_W-1:0] ino;
		logic [LB_W-1:0]  lb;
		int               pick;
		ino  = INO_W'($urandom_range(INODE_COUNT - 1));
		pick = $urandom_range(99);
		if (pick < 10)
			lb = LB_W'($urandom_range(2 ** LB_W - 1, LB_LAST + 1));
		else if (pick < 30)
			lb = LB_W'($urandom_range(DIRECT_ENTRIES - 1));
		else if (pick < 50)
			lb = LB_W'($urandom_range(DIRECT_ENTRIES + 15));
		else
			lb = LB_W'($urandom_range(LB_LAST));
		issue_request(ino, lb, 1'b0, '0);
	endtask

	// Result side: random stalls, and each accepted item checked against the oldest expectation
	always @(posedge clk) begin
		ibm_rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			n_checked++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: physical_block %0d status %0d new_blocks %0d",
					physical_block, status, new_blocks);
				fails++;
			end else begin
				want = pending_rsp.pop_front();
				if (physical_block !== want.physical_block) begin
					$error("physical_block: expected %0d, got %0d",
						want.physical_block, physical_block);
					fails++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fails++;
				end
				if (new_blocks !== want.new_blocks) begin
					$error("new_blocks: expected %0d, got %0d", want.new_blocks, new_blocks);
					fails++;
				end
			end
		end
		rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_inode_block_map_allocator_top NOT OK");
			$finish;
		end
	end

	initial begin
		int k;

		// Predictor reset: empty maps, blocks 0 to 5 reserved
		for (k = 0; k < DIR_DEPTH; k++)
			dir_map[k] = '0;
		for (k = 0; k < INODE_COUNT; k++)
			ind_blk[k] = '0;
		for (k = 0; k < IND_DEPTH; k++)
			ind_map[k] = '0;
		for (k = 0; k < DISK_BLOCKS; k++)
			used_map[k] = (k < FIRST_FREE);
		free_ptr = FIRST_FREE;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (k = 0; k < PLAN_ROWS; k++)
			issue_request(plan[k].ino, plan[k].lb, plan[k].typed, plan[k].rsp);

		// Random traffic, with a stretch free of idles and stalls
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			calm = (k >= 700 && k < 1100);
			random_request();
		end
		calm = 1'b0;

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, checked %0d results; %0d blocks allocated",
			n_sent, n_checked, n_taken);
		$display("Disk full answers: %0d, out of range answers: %0d", n_full, n_range);
		if (fails == 0)
			$display("tb_inode_block_map_allocator_top OK");
		else
			$display("tb_inode_block_map_allocator_top NOT OK");
		$finish;
	end

endmodule
